// File: sv/pdo_pkg.sv
`timescale 1ns / 1ps

package pdo_pkg;

  localparam int QUEUE_DEPTH = 4;

  // Strength saturates at d2 >= 21675; below it, S is the largest root with
  // S*S*21675 <= d2 * 2^32
  localparam logic [14:0] STRENGTH_DEN = 15'd21675;
  localparam logic [16:0] STRENGTH_ONE = 17'd65536;
  localparam logic [27:0] GRAY_BIAS    = 28'd12500000;
  localparam logic [7:0]  GRAY_MUL     = 8'd88;

  // Gray = floor(gx / 1000000) = (gx * ceil(2^48 / 1000000)) >> 48, exact for gx < 2^28
  localparam logic [28:0] GRAY_RECIP   = 29'd281474977;
  localparam int          GRAY_SHIFT   = 48;

  localparam logic [7:0] TINT_UP_RED    = 8'd46;
  localparam logic [7:0] TINT_UP_GREEN  = 8'd214;
  localparam logic [7:0] TINT_UP_BLUE   = 8'd255;
  localparam logic [7:0] TINT_DN_RED    = 8'd255;
  localparam logic [7:0] TINT_DN_GREEN  = 8'd138;
  localparam logic [7:0] TINT_DN_BLUE   = 8'd64;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

  // Square-root stages, one strength bit each
  localparam int SQ_STG   = 16;
  localparam int BACK_STG = SQ_STG;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic        last;
    logic        up;
    logic [27:0] gx;
    logic [17:0] d2;
  } mid_t;

  // Back pipeline stage contents
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        up;
    logic        sat;
    logic [7:0]  gray;
    logic [14:0] d2;
    logic [15:0] s;
    logic [31:0] sd;
    logic [47:0] sq;
  } bk_t;

endpackage

// File: sv/pdo_queue.sv
`timescale 1ns / 1ps

module pdo_queue #(
  parameter int DEPTH = pdo_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  pdo_pkg::mid_t wdata,
  output logic          full,
  input  logic          rd,
  output pdo_pkg::mid_t rdata,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pdo_pkg::mid_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if ((wr && !full) && !(rd && !empty)) begin
        count <= count + CW'(1);
      end else if (!(wr && !full) && (rd && !empty)) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: sv/pdo_front.sv
`timescale 1ns / 1ps

module pdo_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    base_red,
  input  logic [7:0]    base_green,
  input  logic [7:0]    base_blue,
  input  logic [7:0]    next_red,
  input  logic [7:0]    next_green,
  input  logic [7:0]    next_blue,
  input  logic          last_in,
  output logic          q_wr,
  output pdo_pkg::mid_t q_data,
  input  logic          q_full
);

  logic          fv;
  pdo_pkg::mid_t item;
  pdo_pkg::mid_t item_next;
  logic [21:0]   lbase;
  logic [21:0]   lnext;
  logic [7:0]    dr;
  logic [7:0]    dg;
  logic [7:0]    db;

  assign full   = fv && q_full;
  assign q_wr   = fv;
  assign q_data = item;

  always_comb begin
    lbase = 22'(22'd2126 * 22'(base_red)) + 22'(22'd7152 * 22'(base_green))
          + 22'(22'd722 * 22'(base_blue));
    lnext = 22'(22'd2126 * 22'(next_red)) + 22'(22'd7152 * 22'(next_green))
          + 22'(22'd722 * 22'(next_blue));
    dr = (next_red   > base_red)   ? next_red   - base_red   : base_red   - next_red;
    dg = (next_green > base_green) ? next_green - base_green : base_green - next_green;
    db = (next_blue  > base_blue)  ? next_blue  - base_blue  : base_blue  - next_blue;
    item_next.last = last_in;
    item_next.up   = (lnext >= lbase);
    item_next.gx   = 28'(28'(pdo_pkg::GRAY_MUL) * 28'(lbase)) + pdo_pkg::GRAY_BIAS;
    item_next.d2   = 18'(16'(dr * dr)) + 18'(16'(dg * dg)) + 18'(16'(db * db));
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (push && !full) begin
      fv <= 1'b1;
    end else if (fv && !q_full) begin
      fv <= 1'b0;
    end
  end

endmodule

// File: sv/pdo_back.sv
`timescale 1ns / 1ps

module pdo_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  pdo_pkg::mid_t q_data,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic          last_out
);

  localparam int NSTG = pdo_pkg::BACK_STG;

  pdo_pkg::bk_t head;
  pdo_pkg::bk_t src [NSTG];
  pdo_pkg::bk_t nxt [NSTG];
  pdo_pkg::bk_t stg [NSTG];
  pdo_pkg::bk_t fin;
  logic         ov;
  logic         adv;
  logic [56:0]  gp;
  logic [16:0]  str;
  logic [7:0]   tr;
  logic [7:0]   tg;
  logic [7:0]   tb;

  function automatic logic [7:0] blend_ch(logic [7:0] g, logic [7:0] tint, logic [16:0] s);
    logic signed [9:0]  dif;
    logic signed [27:0] num;
    dif = $signed({2'b00, tint}) - $signed({2'b00, g});
    num = $signed({4'b0000, g, 16'h0000}) + dif * $signed({1'b0, s}) + 28'sd32768;
    return num[23:16];
  endfunction

  // Whole pipeline holds while the finished result waits
  assign adv   = !ov || pop;
  assign q_rd  = adv && !q_empty;
  assign empty = !ov;

  // Gray by reciprocal multiplication
  always_comb begin
    gp         = 57'(q_data.gx) * 57'(pdo_pkg::GRAY_RECIP);
    head       = '0;
    head.valid = !q_empty;
    head.last  = q_data.last;
    head.up    = q_data.up;
    head.sat   = (q_data.d2 >= 18'(pdo_pkg::STRENGTH_DEN));
    head.gray  = gp[pdo_pkg::GRAY_SHIFT +: 8];
    head.d2    = head.sat ? '0 : q_data.d2[14:0];
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam int B = NSTG - 1 - i;

    if (i == 0) begin : g_head
      assign src[i] = head;
    end else begin : g_link
      assign src[i] = stg[i-1];
    end

    // Try root bit B against d2 * 2^32, everything scaled by DEN:
    // (s + 2^B)^2 * DEN = s^2 * DEN + s * DEN * 2^(B+1) + DEN * 2^(2B)
    always_comb begin
      pdo_pkg::bk_t t;
      logic [48:0]  tsq;
      t   = src[i];
      tsq = 49'(t.sq) + (49'(t.sd) << (B + 1))
          + (49'(pdo_pkg::STRENGTH_DEN) << (2 * B));
      if (tsq <= {2'b00, t.d2, 32'h0000_0000}) begin
        t.sq = tsq[47:0];
        t.sd = t.sd + (32'(pdo_pkg::STRENGTH_DEN) << B);
        t.s  = t.s | (16'd1 << B);
      end
      nxt[i] = t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i].valid <= 1'b0;
      end else if (adv) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign fin = stg[NSTG-1];

  always_comb begin
    str = fin.sat ? pdo_pkg::STRENGTH_ONE : {1'b0, fin.s};
    tr  = fin.up ? pdo_pkg::TINT_UP_RED   : pdo_pkg::TINT_DN_RED;
    tg  = fin.up ? pdo_pkg::TINT_UP_GREEN : pdo_pkg::TINT_DN_GREEN;
    tb  = fin.up ? pdo_pkg::TINT_UP_BLUE  : pdo_pkg::TINT_DN_BLUE;
  end

  assign out_alpha = pdo_pkg::ALPHA_OPAQUE;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= blend_ch(fin.gray, tr, str);
      out_green <= blend_ch(fin.gray, tg, str);
      out_blue  <= blend_ch(fin.gray, tb, str);
      last_out  <= fin.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= fin.valid;
    end
  end

endmodule

// File: sv/pixel_difference_overlay_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     push / full        base_red/green/blue, next_red/green/blue, last_in
// result    pop / empty        out_red/green/blue, out_alpha, last_out
//
// One pixel per clock sustained while pop is held high. A pixel passes the front
// register, which loads at the push transfer, then a queue write, the 16
// square-root stages and the blend register, where the result shows.
// Synchronous reset empties the front stage, queue and back pipeline.
// A held result stalls the back pipeline; the front keeps taking pixels until
// the queue and front register are full.

module pixel_difference_overlay_unit #(
  parameter int QUEUE_DEPTH = pdo_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] base_red,
  input  logic [7:0] base_green,
  input  logic [7:0] base_blue,
  input  logic [7:0] next_red,
  input  logic [7:0] next_green,
  input  logic [7:0] next_blue,
  input  logic       last_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       last_out
);

  logic          q_wr;
  logic          q_full;
  logic          q_rd;
  logic          q_empty;
  pdo_pkg::mid_t q_wdata;
  pdo_pkg::mid_t q_rdata;

  pdo_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .base_red   (base_red),
    .base_green (base_green),
    .base_blue  (base_blue),
    .next_red   (next_red),
    .next_green (next_green),
    .next_blue  (next_blue),
    .last_in    (last_in),
    .q_wr       (q_wr),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  pdo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pdo_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .last_out  (last_out)
  );

endmodule

// File: sv/pdo_checker.sv
`timescale 1ns / 1ps

module pdo_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       last_out
);

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_alpha == pdo_pkg::ALPHA_OPAQUE)
    else $error("alpha not opaque");

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

  a_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({out_red, out_green, out_blue, last_out}))
    else $error("result has unknown bits");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_red) && $stable(out_green)
                       && $stable(out_blue) && $stable(last_out))
    else $error("held result changed");

endmodule

bind pixel_difference_overlay_unit pdo_checker u_pdo_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha),
  .last_out  (last_out)
);
